@@ hdl/tbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared types and constants of the triangle barycentric rasterizer.
// ----------------------------------------------------------------------------
package tbr_pkg;

    localparam int CROP_SIZE_DEF = 64;
    localparam int CHANNELS_DEF  = 2;

    localparam int CW = 20;  // vertex coordinate width
    localparam int VW = 24;  // feature value width
    localparam int DW = 48;  // determinant and edge function width
    localparam int MW = 33;  // shared multiplier operand width
    localparam int PW = 66;  // shared multiplier product width
    localparam int QW = 63;  // reciprocal width
    localparam int WW = 17;  // weight width

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

@@ hdl/tbr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tbr_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tbr_mul (
    input  logic                           i_clk,
    input  logic signed [tbr_pkg::MW-1:0]  i_a,
    input  logic signed [tbr_pkg::MW-1:0]  i_b,
    output logic signed [tbr_pkg::PW-1:0]  o_p
);

    logic signed [tbr_pkg::PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ hdl/tbr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_div
// Bit-serial restoring divider that forms floor(2^62 / den), one bit a cycle.
// ----------------------------------------------------------------------------
module tbr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tbr_pkg::t_div_req             i_req,
    output tbr_pkg::t_div_sts             o_sts,
    output logic [tbr_pkg::QW-1:0]        o_quot
);

    localparam int DW = tbr_pkg::DW;
    localparam int QW = tbr_pkg::QW;
    localparam logic [5:0] TOP_BIT = 6'(QW - 1);

    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_quot;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem[DW-1:0], (r_cnt == TOP_BIT)};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= TOP_BIT;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem  <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quot <= {r_quot[QW-2:0], fits};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

@@ hdl/triangle_barycentric_rasterizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_barycentric_rasterizer_top
// Square raster of signed 24-bit feature channels with clear, triangle draw
// and pixel read commands.
// ----------------------------------------------------------------------------
// A command is a transaction taken when start is high and busy is low. The
// result appears for one cycle with o_done high; the receiver cannot stall.
// Read returns o_read_value, draw reports o_skipped for a zero determinant.
// Every command is serviced alone; busy stays high until its result.
// A clear writes zero to every word, DEPTH = CROP_SIZE * CROP_SIZE * CHANNELS
// of them (one RAM word a cycle through the write port). A draw computes the
// determinant and edge functions, runs the serial reciprocal divider, then
// visits each pixel of the clipped box, using the shared multiplier for each
// pixel inside the triangle (9 products, each issued in S_MUL and accumulated
// in S_ACC), and then gives its result.
// A degenerate or off-crop draw skips the divider and the scan.
// After reset the block runs the same clearing pass as the clear command,
// with busy high and no result.
// ----------------------------------------------------------------------------
module triangle_barycentric_rasterizer_top #(
    parameter int CROP_SIZE = tbr_pkg::CROP_SIZE_DEF,
    parameter int CHANNELS  = tbr_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_op,
    input  logic signed [19:0]          i_ax,
    input  logic signed [19:0]          i_ay,
    input  logic signed [19:0]          i_bx,
    input  logic signed [19:0]          i_by_coord,
    input  logic signed [19:0]          i_cx,
    input  logic signed [19:0]          i_cy,
    input  logic signed [23:0]          i_value_a,
    input  logic signed [23:0]          i_value_b,
    input  logic signed [23:0]          i_value_c,
    input  logic                        i_channel,
    input  logic [11:0]                 i_pixel_index,
    output logic                        o_done,
    output logic signed [23:0]          o_read_value,
    output logic                        o_skipped
);

    localparam int DW    = tbr_pkg::DW;
    localparam int MW    = tbr_pkg::MW;
    localparam int PW    = tbr_pkg::PW;
    localparam int QW    = tbr_pkg::QW;
    localparam int WW    = tbr_pkg::WW;
    localparam int VW    = tbr_pkg::VW;
    localparam int SW    = 48;
    localparam int BW    = 14;
    localparam int DEPTH = CROP_SIZE * CROP_SIZE * CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(CROP_SIZE);
    localparam int PIXELS = CROP_SIZE * CROP_SIZE;
    localparam logic signed [BW-1:0] LIM = BW'(CROP_SIZE - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(CROP_SIZE * CHANNELS);
    localparam logic [AW-1:0] COL_STEP  = AW'(CHANNELS);
    localparam logic signed [VW-1:0] VMAX = 24'sh7FFFFF;
    localparam logic signed [VW-1:0] VMIN = -24'sh800000;

    localparam logic [3:0] K_DET0 = 4'd0;
    localparam logic [3:0] K_DET1 = 4'd1;
    localparam logic [3:0] K_E1A  = 4'd2;
    localparam logic [3:0] K_E1B  = 4'd3;
    localparam logic [3:0] K_E2A  = 4'd4;
    localparam logic [3:0] K_E2B  = 4'd5;
    localparam logic [3:0] K_W1A  = 4'd6;
    localparam logic [3:0] K_W1B  = 4'd7;
    localparam logic [3:0] K_W1C  = 4'd8;
    localparam logic [3:0] K_W2A  = 4'd9;
    localparam logic [3:0] K_W2B  = 4'd10;
    localparam logic [3:0] K_W2C  = 4'd11;
    localparam logic [3:0] K_S0   = 4'd12;
    localparam logic [3:0] K_S1   = 4'd13;
    localparam logic [3:0] K_S2   = 4'd14;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CLEAR = 12'b000000000010,
        S_RD0   = 12'b000000000100,
        S_RD1   = 12'b000000001000,
        S_SET   = 12'b000000010000,
        S_MUL   = 12'b000000100000,
        S_ACC   = 12'b000001000000,
        S_CHECK = 12'b000010000000,
        S_DIV   = 12'b000100000000,
        S_PIX   = 12'b001000000000,
        S_NEXT  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    t_state r_state;
    logic   r_clr_op;
    logic [AW-1:0] r_clr;

    logic [11:0]            r_pix;
    logic                   r_ch;
    logic signed [19:0]     r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [VW-1:0]   r_va, r_vb, r_vc;
    logic signed [20:0]     r_v0x, r_v0y, r_v1x, r_v1y;
    logic                   r_out;
    logic [XW-1:0]          r_x0, r_x1, r_y0, r_y1, r_x, r_y;
    logic signed [DW-1:0]   r_t, r_det, r_e1, r_e2, r_e1r, r_e2r;
    logic                   r_neg;
    logic [DW-1:0]          r_n1, r_n2;
    logic [QW-1:0]          r_r;
    logic [63:0]            r_acc;
    logic [WW-1:0]          r_w1, r_w2;
    logic signed [SW-1:0]   r_sum;
    logic [3:0]             r_k;
    logic [AW-1:0]          r_addr, r_rowaddr;
    logic                   r_rdok;
    logic signed [VW-1:0]   r_rv;
    logic                   r_sk;
    logic                   r_done;
    logic signed [VW-1:0]   r_o_value;
    logic                   r_o_skip;

    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   mul_p;
    tbr_pkg::t_div_req      div_req;
    tbr_pkg::t_div_sts      div_sts;
    logic [QW-1:0]          div_quot;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VW-1:0]          ram_rdata;

    // Bounding box and differences.
    logic signed [19:0]     minx, maxx, miny, maxy;
    logic signed [20:0]     maxx_r, maxy_r;
    logic signed [BW-1:0]   fx0, fx1, fy0, fy1;

    // Pixel datapath.
    logic signed [21:0]     v2x, v2y;
    logic signed [DW-1:0]   n1s, n2s;
    logic signed [DW:0]     nsum;
    logic                   in_tri;
    logic signed [DW-1:0]   dx1, dy1, dx2, dy2;
    logic [63:0]            acc_n;
    logic [63:0]            acc_r;
    logic signed [18:0]     w0s;
    logic [WW-1:0]          w0;
    logic signed [SW-1:0]   s_fin;
    logic signed [SW-1:0]   s_shr;
    logic signed [VW-1:0]   q_sat;
    logic                   ch_ok;

    function automatic logic signed [19:0] min2(input logic signed [19:0] a,
                                                input logic signed [19:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [19:0] max2(input logic signed [19:0] a,
                                                input logic signed [19:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [XW-1:0] clip(input logic signed [BW-1:0] v);
        logic signed [BW-1:0] c;
        c = v;
        if (v < 0) begin
            c = '0;
        end else if (v > LIM) begin
            c = LIM;
        end
        return XW'(c);
    endfunction

    assign ch_ok = (32'(r_ch) < CHANNELS);

    assign minx   = min2(min2(r_ax, r_bx), r_cx);
    assign maxx   = max2(max2(r_ax, r_bx), r_cx);
    assign miny   = min2(min2(r_ay, r_by), r_cy);
    assign maxy   = max2(max2(r_ay, r_by), r_cy);
    assign maxx_r = 21'(maxx) + 21'sd255;
    assign maxy_r = 21'(maxy) + 21'sd255;
    assign fx0    = BW'(minx >>> 8);
    assign fy0    = BW'(miny >>> 8);
    assign fx1    = BW'(maxx_r >>> 8) + BW'(1);
    assign fy1    = BW'(maxy_r >>> 8) + BW'(1);

    assign v2x = $signed({{(14 - XW){1'b0}}, r_x0, 8'b0}) - 22'(r_ax);
    assign v2y = $signed({{(14 - XW){1'b0}}, r_y0, 8'b0}) - 22'(r_ay);

    assign dx1 = DW'(r_v1y) <<< 8;
    assign dy1 = -(DW'(r_v1x) <<< 8);
    assign dx2 = -(DW'(r_v0y) <<< 8);
    assign dy2 = DW'(r_v0x) <<< 8;

    assign n1s    = r_neg ? -r_e1 : r_e1;
    assign n2s    = r_neg ? -r_e2 : r_e2;
    assign nsum   = (DW + 1)'(n1s) + (DW + 1)'(n2s);
    assign in_tri = (n1s >= 0) && (n2s >= 0) && (nsum <= (DW + 1)'(r_det));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_k)
            K_DET0: begin mul_a = MW'(r_v0x); mul_b = MW'(r_v1y); end
            K_DET1: begin mul_a = MW'(r_v1x); mul_b = MW'(r_v0y); end
            K_E1A:  begin mul_a = MW'(v2x);   mul_b = MW'(r_v1y); end
            K_E1B:  begin mul_a = MW'(r_v1x); mul_b = MW'(v2y);   end
            K_E2A:  begin mul_a = MW'(r_v0x); mul_b = MW'(v2y);   end
            K_E2B:  begin mul_a = MW'(v2x);   mul_b = MW'(r_v0y); end
            K_W1A: begin
                mul_a = $signed({1'b0, r_n1[31:0]});
                mul_b = $signed({1'b0, r_r[31:0]});
            end
            K_W1B: begin
                mul_a = $signed({1'b0, r_n1[31:0]});
                mul_b = $signed({2'b0, r_r[QW-1:32]});
            end
            K_W1C: begin
                mul_a = $signed({{(MW - DW + 32){1'b0}}, r_n1[DW-1:32]});
                mul_b = $signed({1'b0, r_r[31:0]});
            end
            K_W2A: begin
                mul_a = $signed({1'b0, r_n2[31:0]});
                mul_b = $signed({1'b0, r_r[31:0]});
            end
            K_W2B: begin
                mul_a = $signed({1'b0, r_n2[31:0]});
                mul_b = $signed({2'b0, r_r[QW-1:32]});
            end
            K_W2C: begin
                mul_a = $signed({{(MW - DW + 32){1'b0}}, r_n2[DW-1:32]});
                mul_b = $signed({1'b0, r_r[31:0]});
            end
            K_S0: begin mul_a = $signed({{(MW - WW){1'b0}}, w0});   mul_b = MW'(r_va); end
            K_S1: begin mul_a = $signed({{(MW - WW){1'b0}}, r_w1}); mul_b = MW'(r_vb); end
            K_S2: begin mul_a = $signed({{(MW - WW){1'b0}}, r_w2}); mul_b = MW'(r_vc); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign w0s = 19'sd65536 - $signed({2'b0, r_w1}) - $signed({2'b0, r_w2});
    assign w0  = (w0s < 0) ? '0 : WW'(w0s);

    assign acc_n = r_acc + {mul_p[31:0], 32'b0};
    assign acc_r = acc_n + 64'h0000_2000_0000_0000;

    assign s_fin = r_sum + SW'(mul_p) + SW'(32768);
    assign s_shr = s_fin >>> 16;
    always_comb begin
        q_sat = VW'(s_shr);
        if (s_shr > SW'(VMAX)) begin
            q_sat = VMAX;
        end else if (s_shr < SW'(VMIN)) begin
            q_sat = VMIN;
        end
    end

    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_ACC) && (r_k == K_S2));
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : q_sat;
    assign ram_raddr = AW'(32'(r_pix) * CHANNELS + 32'(r_ch));

    assign div_req.start = (r_state == S_CHECK) && (r_det != '0) && !r_out && ch_ok;
    assign div_req.den   = (r_det < 0) ? -r_det : r_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_clr_op <= 1'b0;
            r_done   <= 1'b0;
            r_k      <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (tbr_pkg::t_op'(i_op))
                            tbr_pkg::OP_CLEAR: begin
                                r_clr    <= '0;
                                r_clr_op <= 1'b1;
                                r_state  <= S_CLEAR;
                            end
                            tbr_pkg::OP_DRAW: r_state <= S_SET;
                            tbr_pkg::OP_READ: r_state <= S_RD0;
                            default:          r_state <= S_DONE;
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (r_clr == LAST_ADDR) begin
                        r_state <= r_clr_op ? S_DONE : S_IDLE;
                    end else begin
                        r_clr <= r_clr + AW'(1);
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: r_state <= S_DONE;
                S_SET: begin
                    r_k     <= K_DET0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    if (r_k == K_E2B) begin
                        r_state <= S_CHECK;
                    end else if (r_k == K_S2) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_CHECK: r_state <= div_req.start ? S_DIV : S_DONE;
                S_DIV: begin
                    if (div_sts.done) begin
                        r_state <= S_PIX;
                    end
                end
                S_PIX: begin
                    if (in_tri) begin
                        r_k     <= K_W1A;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_x != r_x1 || r_y != r_y1) begin
                        r_state <= S_PIX;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pix <= i_pixel_index;
                r_ch  <= i_channel;
                r_ax  <= i_ax;
                r_ay  <= i_ay;
                r_bx  <= i_bx;
                r_by  <= i_by_coord;
                r_cx  <= i_cx;
                r_cy  <= i_cy;
                r_va  <= i_value_a;
                r_vb  <= i_value_b;
                r_vc  <= i_value_c;
                r_rv  <= '0;
                r_sk  <= 1'b0;
            end
            S_RD0: r_rdok <= (32'(r_pix) < PIXELS) && ch_ok;
            S_RD1: r_rv <= r_rdok ? $signed(ram_rdata) : '0;
            S_SET: begin
                r_v0x <= 21'(r_bx) - 21'(r_ax);
                r_v0y <= 21'(r_by) - 21'(r_ay);
                r_v1x <= 21'(r_cx) - 21'(r_ax);
                r_v1y <= 21'(r_cy) - 21'(r_ay);
                r_out <= (fx1 < 0) || (fy1 < 0) || (fx0 > LIM) || (fy0 > LIM);
                r_x0  <= clip(fx0);
                r_x1  <= clip(fx1);
                r_y0  <= clip(fy0);
                r_y1  <= clip(fy1);
            end
            S_ACC: begin
                case (r_k)
                    K_DET0, K_E1A, K_E2A: r_t <= DW'(mul_p);
                    K_DET1: r_det <= r_t - DW'(mul_p);
                    K_E1B: begin
                        r_e1  <= r_t - DW'(mul_p);
                        r_e1r <= r_t - DW'(mul_p);
                    end
                    K_E2B: begin
                        r_e2  <= r_t - DW'(mul_p);
                        r_e2r <= r_t - DW'(mul_p);
                    end
                    K_W1A, K_W2A: r_acc <= mul_p[63:0];
                    K_W1B, K_W2B: r_acc <= acc_n;
                    K_W1C: r_w1 <= acc_r[62:46];
                    K_W2C: r_w2 <= acc_r[62:46];
                    K_S0: r_sum <= SW'(mul_p);
                    K_S1: r_sum <= r_sum + SW'(mul_p);
                    default: r_sum <= r_sum;
                endcase
            end
            S_CHECK: begin
                r_sk      <= (r_det == '0);
                r_neg     <= (r_det < 0);
                r_det     <= (r_det < 0) ? -r_det : r_det;
                r_x       <= r_x0;
                r_y       <= r_y0;
                r_addr    <= AW'(32'(r_y0) * (CROP_SIZE * CHANNELS)
                                 + 32'(r_x0) * CHANNELS + 32'(r_ch));
                r_rowaddr <= AW'(32'(r_y0) * (CROP_SIZE * CHANNELS)
                                 + 32'(r_x0) * CHANNELS + 32'(r_ch));
            end
            S_DIV: r_r <= div_quot;
            S_PIX: begin
                r_n1 <= n1s;
                r_n2 <= n2s;
            end
            S_NEXT: begin
                if (r_x != r_x1) begin
                    r_x    <= r_x + XW'(1);
                    r_e1   <= r_e1 + dx1;
                    r_e2   <= r_e2 + dx2;
                    r_addr <= r_addr + COL_STEP;
                end else if (r_y != r_y1) begin
                    r_y       <= r_y + XW'(1);
                    r_x       <= r_x0;
                    r_e1      <= r_e1r + dy1;
                    r_e2      <= r_e2r + dy2;
                    r_e1r     <= r_e1r + dy1;
                    r_e2r     <= r_e2r + dy2;
                    r_addr    <= r_rowaddr + ROW_STEP;
                    r_rowaddr <= r_rowaddr + ROW_STEP;
                end
            end
            S_DONE: begin
                r_o_value <= r_rv;
                r_o_skip  <= r_sk;
            end
            default: r_t <= r_t;
        endcase
    end

    tbr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    tbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    tbr_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_read_value = r_done ? r_o_value : '0;
    assign o_skipped    = r_done ? r_o_skip : 1'b0;

endmodule

@@ hdl/tbr_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbr_chk
// Port-level checks of the rasterizer command and result timing.
// ----------------------------------------------------------------------------
module tbr_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic signed [23:0] o_read_value,
    input logic               o_skipped
);

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding busy period");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_skip_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_skipped |-> o_done)
        else $error("skipped flag outside a result");

    a_value_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_read_value != 24'sd0) |-> o_done)
        else $error("read value outside a result");

endmodule

bind triangle_barycentric_rasterizer_top tbr_chk u_tbr_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_read_value (o_read_value),
    .o_skipped    (o_skipped)
);

@@ tb/tb_triangle_barycentric_rasterizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_barycentric_rasterizer_top
// Self-checking testbench for the triangle barycentric rasterizer.
// ----------------------------------------------------------------------------
// A short table of directed commands covers the empty raster after reset, the
// field extremes, degenerate and off-crop triangles, the unused operation and
// a clear. Random commands follow: mostly small triangles with reads around
// them, plus off-crop noise, degenerate draws and a few clears. Each result
// is checked against the table's value or a raster model in the testbench.
// ----------------------------------------------------------------------------
module tb_triangle_barycentric_rasterizer_top;

    localparam int SIDE   = tbr_pkg::CROP_SIZE_DEF;
    localparam int NCHAN  = tbr_pkg::CHANNELS_DEF;
    localparam int NRAND  = 1150;

    typedef struct {
        tbr_pkg::t_op       op;
        logic signed [19:0] ax, ay, bx, byc, cx, cy;
        logic signed [23:0] va, vb, vc;
        logic               ch;
        logic [11:0]        pix;
        bit                 typed;
        logic signed [23:0] t_rd;
        logic               t_sk;
    } t_cmd;

    typedef struct {
        logic signed [23:0] rd;
        logic               sk;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic o_done;
    logic signed [23:0] o_read_value;
    logic o_skipped;
    t_cmd cur = '{op: tbr_pkg::OP_CLEAR, default: '0};

    logic signed [23:0] raster [SIDE*SIDE*NCHAN];
    t_res pending [$];
    int errors = 0;
    int n_draw = 0, n_read = 0, n_clear = 0, n_skip = 0;
    int lastx = 8, lasty = 8;

    always #2 i_clk = ~i_clk;

    triangle_barycentric_rasterizer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(cur.op), .i_ax(cur.ax), .i_ay(cur.ay), .i_bx(cur.bx),
        .i_by_coord(cur.byc), .i_cx(cur.cx), .i_cy(cur.cy),
        .i_value_a(cur.va), .i_value_b(cur.vb), .i_value_c(cur.vc),
        .i_channel(cur.ch), .i_pixel_index(cur.pix),
        .o_done(o_done), .o_read_value(o_read_value), .o_skipped(o_skipped)
    );

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic draw_triangle(input t_cmd c, output logic sk);
        longint v0x, v0y, v1x, v1y, v2x, v2y, det, n1, n2, sg;
        longint x0, x1, y0, y1, w0, w1, w2, s, q;
        longint unsigned r;
        v0x = c.bx - c.ax; v0y = c.byc - c.ay;
        v1x = c.cx - c.ax; v1y = c.cy - c.ay;
        det = v0x * v1y - v1x * v0y;
        sk = 1'b0;
        if (det == 0) begin
            sk = 1'b1;
            return;
        end
        sg = 1;
        if (det < 0) begin
            det = -det;
            sg = -1;
        end
        r = (64'd1 << 62) / longint'(det);
        x0 = longint'(c.ax) < c.bx ? c.ax : c.bx; if (c.cx < x0) x0 = c.cx;
        x1 = longint'(c.ax) > c.bx ? c.ax : c.bx; if (c.cx > x1) x1 = c.cx;
        y0 = longint'(c.ay) < c.byc ? c.ay : c.byc; if (c.cy < y0) y0 = c.cy;
        y1 = longint'(c.ay) > c.byc ? c.ay : c.byc; if (c.cy > y1) y1 = c.cy;
        x0 = x0 >>> 8; y0 = y0 >>> 8;
        x1 = -((-x1) >>> 8) + 1; y1 = -((-y1) >>> 8) + 1;
        if (x1 < 0 || y1 < 0 || x0 > SIDE - 1 || y0 > SIDE - 1) return;
        if (x0 < 0) x0 = 0; if (y0 < 0) y0 = 0;
        if (x1 > SIDE - 1) x1 = SIDE - 1; if (y1 > SIDE - 1) y1 = SIDE - 1;
        for (longint y = y0; y <= y1; y++) begin
            for (longint x = x0; x <= x1; x++) begin
                v2x = x * 256 - c.ax; v2y = y * 256 - c.ay;
                n1 = sg * (v2x * v1y - v1x * v2y);
                n2 = sg * (v0x * v2y - v2x * v0y);
                if (n1 < 0 || n2 < 0 || n1 + n2 > det) continue;
                w1 = longint'((longint'(unsigned'(n1)) * r + (64'd1 << 45)) >> 46);
                w2 = longint'((longint'(unsigned'(n2)) * r + (64'd1 << 45)) >> 46);
                w0 = 65536 - w1 - w2;
                if (w0 < 0) w0 = 0;
                s = w0 * c.va + w1 * c.vb + w2 * c.vc + 32768;
                q = s >>> 16;
                if (q > 8388607) q = 8388607;
                if (q < -8388608) q = -8388608;
                raster[(y * SIDE + x) * NCHAN + c.ch] = q[23:0];
            end
        end
    endtask

    task automatic run_command(input t_cmd c, output t_res res);
        res.rd = '0;
        res.sk = 1'b0;
        case (c.op)
            tbr_pkg::OP_CLEAR: begin
                foreach (raster[i]) raster[i] = '0;
                n_clear++;
            end
            tbr_pkg::OP_DRAW: begin
                draw_triangle(c, res.sk);
                n_draw++;
            end
            tbr_pkg::OP_READ: begin
                res.rd = raster[c.pix * NCHAN + c.ch];
                n_read++;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_res want, got;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending.size() == 0) begin
                    report("unexpected transaction", o_read_value, 0);
                end else begin
                    want = pending.pop_front();
                    if (o_read_value !== want.rd) report("read_value", o_read_value, want.rd);
                    if (o_skipped !== want.sk) report("skipped", o_skipped, want.sk);
                    if (o_skipped === 1'b1) n_skip++;
                end
            end
            if (start && !busy) begin
                run_command(cur, got);
                if (cur.typed) begin
                    got.rd = cur.t_rd;
                    got.sk = cur.t_sk;
                end
                pending.push_back(got);
            end
        end
    end

    function automatic t_cmd mk(tbr_pkg::t_op op, int ax, int ay, int bx, int byc,
                                int cx, int cy, int va, int vb, int vc, bit ch, int pix,
                                bit typed = 0, int rd = 0, bit sk = 0);
        t_cmd c;
        c.op = op; c.ax = 20'(ax); c.ay = 20'(ay); c.bx = 20'(bx);
        c.byc = 20'(byc); c.cx = 20'(cx); c.cy = 20'(cy);
        c.va = 24'(va); c.vb = 24'(vb); c.vc = 24'(vc); c.ch = ch; c.pix = 12'(pix);
        c.typed = typed; c.t_rd = 24'(rd); c.t_sk = sk;
        return c;
    endfunction

    function automatic int rnd_value();
        case ($urandom_range(0, 9))
            0: return 8388607;
            1: return -8388608;
            default: return int'($urandom_range(0, 16777215)) - 8388608;
        endcase
    endfunction

    function automatic t_cmd rnd_command();
        t_cmd c;
        int sel, bx0, by0, px, py;
        c = mk(tbr_pkg::OP_DRAW, 0, 0, 0, 0, 0, 0, rnd_value(), rnd_value(), rnd_value(),
               1'($urandom_range(0, 1)), int'($urandom_range(0, 4095)));
        c.ax = 20'($urandom); c.ay = 20'($urandom); c.bx = 20'($urandom);
        c.byc = 20'($urandom); c.cx = 20'($urandom); c.cy = 20'($urandom);
        sel = $urandom_range(0, 999);
        if (sel < 4) begin
            c.op = tbr_pkg::OP_CLEAR;
        end else if (sel < 40) begin
            c.op = tbr_pkg::OP_NONE;
        end else if (sel < 540) begin
            c.op = tbr_pkg::OP_READ;
            if ($urandom_range(0, 1)) begin
                px = lastx + int'($urandom_range(0, 8)) - 2;
                py = lasty + int'($urandom_range(0, 8)) - 2;
                px = px < 0 ? 0 : (px > SIDE - 1 ? SIDE - 1 : px);
                py = py < 0 ? 0 : (py > SIDE - 1 ? SIDE - 1 : py);
                c.pix = 12'(py * SIDE + px);
            end
        end else if (sel < 620) begin
            // Off-crop noise: all three vertices beyond one edge of the crop.
            case ($urandom_range(0, 3))
                0: begin
                    c.ax = 20'(-600 - int'($urandom_range(0, 523000)));
                    c.bx = 20'(-600 - int'($urandom_range(0, 523000)));
                    c.cx = 20'(-600 - int'($urandom_range(0, 523000)));
                end
                1: begin
                    c.ax = 20'(16384 + int'($urandom_range(0, 507903)));
                    c.bx = 20'(16384 + int'($urandom_range(0, 507903)));
                    c.cx = 20'(16384 + int'($urandom_range(0, 507903)));
                end
                2: begin
                    c.ay = 20'(-600 - int'($urandom_range(0, 523000)));
                    c.byc = 20'(-600 - int'($urandom_range(0, 523000)));
                    c.cy = 20'(-600 - int'($urandom_range(0, 523000)));
                end
                default: begin
                    c.ay = 20'(16384 + int'($urandom_range(0, 507903)));
                    c.byc = 20'(16384 + int'($urandom_range(0, 507903)));
                    c.cy = 20'(16384 + int'($urandom_range(0, 507903)));
                end
            endcase
        end else begin
            bx0 = int'($urandom_range(0, 72 * 256)) - 4 * 256;
            by0 = int'($urandom_range(0, 72 * 256)) - 4 * 256;
            c.ax = 20'(bx0 + int'($urandom_range(0, 1536)));
            c.ay = 20'(by0 + int'($urandom_range(0, 1536)));
            c.bx = 20'(bx0 + int'($urandom_range(0, 1536)));
            c.byc = 20'(by0 + int'($urandom_range(0, 1536)));
            c.cx = 20'(bx0 + int'($urandom_range(0, 1536)));
            c.cy = 20'(by0 + int'($urandom_range(0, 1536)));
            if (sel > 960) begin
                c.cx = c.ax;
                c.cy = c.ay;
            end
            lastx = (bx0 >>> 8) + 2;
            lasty = (by0 >>> 8) + 2;
        end
        return c;
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic issue(input t_cmd c, inout int burst_left);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        cur <= c;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    t_cmd dir [$];

    initial begin
        int burst_left;
        burst_left = 0;
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 4095, 1, 0, 0));
        dir.push_back(mk(tbr_pkg::OP_NONE, 524287, 524287, 524287, 524287, 524287, 524287,
                         8388607, 8388607, 8388607, 1, 4095, 1, 0, 0));
        dir.push_back(mk(tbr_pkg::OP_DRAW, 2560, 2560, 2560, 2560, 2560, 2560,
                         5, 6, 7, 0, 0, 1, 0, 1));
        dir.push_back(mk(tbr_pkg::OP_DRAW, -524288, -524288, 0, 0, 262144, 262144,
                         -8388608, 8388607, 1, 1, 0, 1, 0, 1));
        dir.push_back(mk(tbr_pkg::OP_DRAW, -524288, 100, -524288, 9000, -300000, 5000,
                         1, 2, 3, 0, 0, 1, 0, 0));
        dir.push_back(mk(tbr_pkg::OP_DRAW, 1280, 1280, 3840, 1280, 1280, 3840,
                         8388607, 8388607, 8388607, 0, 0));
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5 * SIDE + 5));
        dir.push_back(mk(tbr_pkg::OP_DRAW, 1280, 1280, 1280, 3840, 3840, 1280,
                         -8388608, -8388608, -8388608, 1, 0));
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 6 * SIDE + 6));
        dir.push_back(mk(tbr_pkg::OP_DRAW, 5000, 6100, 7200, 5300, 5900, 7777,
                         1000000, -2000000, 3000000, 0, 0));
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24 * SIDE + 23));
        dir.push_back(mk(tbr_pkg::OP_DRAW, 0, 0, 16384, 0, 0, 16384,
                         8388607, -8388608, 12345, 0, 0));
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10 * SIDE + 20));
        dir.push_back(mk(tbr_pkg::OP_DRAW, -524288, -524288, 524287, -524288,
                         -524288, 524287, -8388608, 8388607, 8388607, 1, 0));
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 4095));
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        dir.push_back(mk(tbr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10 * SIDE + 20,
                         1, 0, 0));
        dir.push_back(mk(tbr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 4095, 1, 0, 0));

        foreach (raster[i]) raster[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir[i]) issue(dir[i], burst_left);
        drain();
        for (int i = 0; i < NRAND; i++) begin
            if (i == NRAND / 2) drain();
            issue(rnd_command(), burst_left);
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d draws (%0d degenerate), %0d reads and %0d clears.",
                 n_draw, n_skip, n_read, n_clear);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/tbr_pkg.sv
hdl/tbr_ram.sv
hdl/tbr_mul.sv
hdl/tbr_div.sv
hdl/triangle_barycentric_rasterizer_top.sv
hdl/tbr_chk.sv
tb/tb_triangle_barycentric_rasterizer_top.sv
